FILE: src/u8sf_pkg.sv
`timescale 1ns / 1ps

package u8sf_pkg;

	typedef logic [7:0]  byte_t;
	typedef logic [20:0] cp_t;
	typedef logic [2:0]  len_t;

	// up to four output bytes, data[0] goes out first
	typedef struct packed {
		byte_t [3:0] data;
		len_t        cnt;
	} grp_t;

	localparam byte_t MASK_LEN4  = 8'hF8;
	localparam byte_t LEAD_LEN4  = 8'hF0;
	localparam byte_t MASK_LEN3  = 8'hF0;
	localparam byte_t LEAD_LEN3  = 8'hE0;
	localparam byte_t MASK_LEN2  = 8'hE0;
	localparam byte_t LEAD_LEN2  = 8'hC0;

	localparam cp_t VS_LO      = 21'h00FE00;
	localparam cp_t VS_HI      = 21'h00FE0F;
	localparam cp_t VS_SUP_LO  = 21'h0E0100;
	localparam cp_t VS_SUP_HI  = 21'h0E01EF;
	localparam cp_t WAVE_DASH  = 21'h00301C;
	localparam cp_t DOLLAR_CP  = 21'h000024;

	localparam byte_t DOLLAR   = 8'h24;
	localparam byte_t FW_TILDE0 = 8'hEF;
	localparam byte_t FW_TILDE1 = 8'hBD;
	localparam byte_t FW_TILDE2 = 8'h9E;

	function automatic len_t lead_len(input byte_t b);
		len_t n;
		if ((b & MASK_LEN4) == LEAD_LEN4)
			n = 3'd4;
		else if ((b & MASK_LEN3) == LEAD_LEN3)
			n = 3'd3;
		else if ((b & MASK_LEN2) == LEAD_LEN2)
			n = 3'd2;
		else if (!b[7])
			n = 3'd1;
		else
			n = 3'd0;
		return n;
	endfunction

	// complete sequence b0..b(len-1) -> output bytes
	function automatic grp_t emit_seq(input byte_t b0, input byte_t b1, input byte_t b2,
		input byte_t b3, input len_t len);
		cp_t  cp;
		grp_t g;
		case (len)
			3'd4: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			3'd3: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			3'd2: cp = {10'd0, b0[4:0], b1[5:0]};
			default: cp = {13'd0, b0};
		endcase
		g.data = {b3, b2, b1, b0};
		g.cnt  = len;
		if ((cp >= VS_LO && cp <= VS_HI) || (cp >= VS_SUP_LO && cp <= VS_SUP_HI)) begin
			g.cnt = 3'd0;
		end else if (cp == WAVE_DASH) begin
			g.data = {8'd0, FW_TILDE2, FW_TILDE1, FW_TILDE0};
			g.cnt  = 3'd3;
		end else if (cp == DOLLAR_CP) begin
			g.data = {16'd0, DOLLAR, DOLLAR};
			g.cnt  = 3'd2;
		end
		return g;
	endfunction

endpackage

FILE: src/utf8_text_sanitize_filter_core.sv
`timescale 1ns / 1ps

// UTF-8 text sanitizer.
// Input stream s_axis_*: one text byte per transfer, tlast marks the final byte of a text.
// Output stream m_axis_*: sanitized bytes, tlast marks the last byte caused by one input
// transfer. Variation selectors are dropped, the wave dash becomes EF BD 9E, '$' is doubled,
// everything else (bad lead bytes, truncated tails) is passed through as its raw bytes.
// Decode is one combinational pass from the held bytes and the input byte into a result
// register of up to four bytes, which shifts out one byte per cycle while m_axis_tready
// is high. The first result byte is registered and valid in the cycle after the input transfer.
// An input transfer yields 0 to 4 output bytes; the result register drains them one byte
// per cycle while m_axis_tready is high, and its last byte overlaps with the next input
// transfer.
// Reset clears the pending sequence and empties the result register.
// When m_axis_tready is low, the result register holds and s_axis_tready stays low
// until its last byte has been taken.
module utf8_text_sanitize_filter_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast
);

	u8sf_pkg::byte_t [2:0] held_q;
	u8sf_pkg::len_t        seq_len_q;
	logic [1:0]            held_cnt_q;

	u8sf_pkg::byte_t [3:0] data_s1;
	u8sf_pkg::len_t        cnt_s1;

	u8sf_pkg::grp_t  grp;
	u8sf_pkg::len_t  seq_len_n;
	logic [1:0]      held_cnt_n;
	logic            wr_en;
	logic [1:0]      wr_idx;
	logic            s_xfer;
	logic            m_xfer;
	logic            m_done;

	assign m_axis_tvalid = cnt_s1 != 3'd0;
	assign m_axis_tdata  = data_s1[0];
	assign m_axis_tlast  = cnt_s1 == 3'd1;
	assign m_xfer        = m_axis_tvalid && m_axis_tready;
	assign m_done        = m_xfer && m_axis_tlast;
	assign s_axis_tready = !m_axis_tvalid || m_done;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	always_comb begin
		u8sf_pkg::len_t  ln;
		u8sf_pkg::len_t  cnt;
		u8sf_pkg::byte_t b;
		b          = s_axis_tdata;
		ln         = u8sf_pkg::lead_len(b);
		cnt        = {1'b0, held_cnt_q} + 3'd1;
		grp.data   = {24'd0, b};
		grp.cnt    = 3'd0;
		seq_len_n  = 3'd0;
		held_cnt_n = 2'd0;
		wr_en      = 1'b0;
		wr_idx     = held_cnt_q;
		if (held_cnt_q == 2'd0) begin
			if (ln == 3'd1) begin
				grp = u8sf_pkg::emit_seq(b, 8'd0, 8'd0, 8'd0, 3'd1);
			end else if (ln == 3'd0 || s_axis_tlast) begin
				grp.cnt = 3'd1;
			end else begin
				wr_en      = 1'b1;
				held_cnt_n = 2'd1;
				seq_len_n  = ln;
			end
		end else if (cnt >= seq_len_q) begin
			grp = u8sf_pkg::emit_seq(held_q[0],
				(seq_len_q == 3'd2) ? b : held_q[1],
				(seq_len_q == 3'd3) ? b : held_q[2],
				b, seq_len_q);
		end else if (s_axis_tlast) begin
			// truncated tail: raw bytes
			grp.data = {8'd0, b, (held_cnt_q == 2'd1) ? b : held_q[1], held_q[0]};
			grp.cnt  = cnt;
		end else begin
			wr_en      = 1'b1;
			held_cnt_n = held_cnt_q + 2'd1;
			seq_len_n  = seq_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q  <= 3'd0;
			held_cnt_q <= 2'd0;
		end else if (s_xfer) begin
			seq_len_q  <= seq_len_n;
			held_cnt_q <= held_cnt_n;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer && wr_en) begin
			held_q[wr_idx] <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 3'd0;
		end else if (s_xfer) begin
			cnt_s1 <= grp.cnt;
		end else if (m_xfer) begin
			cnt_s1 <= cnt_s1 - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			data_s1 <= grp.data;
		end else if (m_xfer) begin
			data_s1 <= {8'd0, data_s1[3:1]};
		end
	end

	a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
		else $error("input taken while result bytes remain");

	a_seq_state: assert property (@(posedge clk) disable iff (!arst_n)
		(held_cnt_q != 2'd0) |-> (seq_len_q >= 3'd2 && seq_len_q <= 3'd4 &&
		{1'b0, held_cnt_q} < seq_len_q))
		else $error("pending sequence state inconsistent");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_done && !s_xfer) |=> !m_axis_tvalid)
		else $error("output still valid after last byte of run");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 <= 3'd4)
		else $error("result byte count out of range");

endmodule
